@@ sv/okamoto_uchiyama_cipher_unit_top_macros.svh @@
// ----------------------------------------------------------------------------
// okamoto-uchiyama cipher unit assertion macros
// concurrent checks that drop out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef OKAMOTO_UCHIYAMA_CIPHER_UNIT_TOP_MACROS_SVH
`define OKAMOTO_UCHIYAMA_CIPHER_UNIT_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define OU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ou check failed");
// next-cycle implication
`define OU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ou check failed");
`else
`define OU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define OU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ou_pkg.sv @@
// ----------------------------------------------------------------------------
// ou_pkg
// shared types and constants of the okamoto-uchiyama cipher unit
// ----------------------------------------------------------------------------
`default_nettype none

package ou_pkg;

  localparam int DEF_MOD_BITS   = 24;
  localparam int DEF_PRIME_BITS = 12;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic [1:0] {
    ACT_ENCRYPT = 2'd0,
    ACT_DECRYPT = 2'd1,
    ACT_ADD     = 2'd2,
    ACT_SCALAR  = 2'd3
  } ou_action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE    = 3'd0,
    CFG_MODULUS = 3'd1,
    CFG_BASE_G  = 3'd2,
    CFG_BASE_H  = 3'd3,
    CFG_PRIME   = 3'd4,
    CFG_INVERSE = 3'd5
  } ou_cfg_idx_t;

  // arithmetic unit commands
  typedef enum logic {
    CMD_REDUCE = 1'b0,
    CMD_MULMOD = 1'b1
  } ou_cmd_t;

  typedef struct packed {
    logic    start;
    ou_cmd_t cmd;
  } ou_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } ou_rsp_t;

endpackage

`default_nettype wire

@@ sv/ou_channels.sv @@
// ----------------------------------------------------------------------------
// ou channels
// valid/ready stream interfaces for operation and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface ou_in_if import ou_pkg::*; #(parameter int MOD_BITS = DEF_MOD_BITS);
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [MOD_BITS-1:0] operand_a;
  logic [MOD_BITS-1:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface ou_out_if import ou_pkg::*; #(parameter int MOD_BITS = DEF_MOD_BITS);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] value;
  logic                mode_error;
  modport source (output valid, value, mode_error, input ready);
  modport sink   (input valid, value, mode_error, output ready);
endinterface

`default_nettype wire

@@ sv/ou_arith.sv @@
// ----------------------------------------------------------------------------
// ou_arith
// bit-serial modular unit: reduce (remainder and quotient) and shift-add mulmod
// ----------------------------------------------------------------------------
`default_nettype none

module ou_arith import ou_pkg::*; #(
  parameter int W = 2 * DEF_MOD_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ou_req_t      req,
  input  wire logic [W-1:0] opa,
  input  wire logic [W-1:0] opb,
  input  wire logic [W-1:0] modv,
  output ou_rsp_t           rsp,
  output logic [W-1:0]      rem,
  output logic [W-1:0]      quo
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  ou_cmd_t       cmd_r;
  logic          ph_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  q_r;

  logic [W-1:0]  addend;
  logic          cin;
  logic [W:0]    sum;
  logic          ge;
  logic [W:0]    red;
  logic          shift;

  // one add and one compare-subtract per cycle
  always_comb begin
    cin = 1'b0;
    if (cmd_r == CMD_REDUCE) begin
      addend = acc_r;
      cin    = x_r[W-1];
    end else if (ph_r) begin
      addend = x_r[W-1] ? a_r : '0;
    end else begin
      addend = acc_r;
    end
    sum   = {1'b0, acc_r} + {1'b0, addend} + (W+1)'(cin);
    ge    = (sum >= {1'b0, m_r});
    red   = ge ? (sum - {1'b0, m_r}) : sum;
    shift = (cmd_r == CMD_REDUCE) || ph_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cmd_r  <= req.cmd;
      ph_r   <= 1'b0;
      cnt_r  <= CW'(W);
      acc_r  <= '0;
      m_r    <= modv;
      a_r    <= opa;
      x_r    <= (req.cmd == CMD_REDUCE) ? opa : opb;
    end else if (busy_r) begin
      acc_r  <= red[W-1:0];
      ph_r   <= (cmd_r == CMD_MULMOD) ? !ph_r : 1'b0;
      done_r <= shift && (cnt_r == CW'(1));
      if (cmd_r == CMD_REDUCE) begin
        q_r <= {q_r[W-2:0], ge};
      end
      if (shift) begin
        x_r   <= {x_r[W-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rem      = acc_r;
  assign quo      = q_r;

endmodule

`default_nettype wire

@@ sv/okamoto_uchiyama_cipher_unit_top.sv @@
// ----------------------------------------------------------------------------
// okamoto_uchiyama_cipher_unit_top
// okamoto-uchiyama encrypt, decrypt, ciphertext add and scalar multiply
// ----------------------------------------------------------------------------
// usage: one operation beat on in_ch (action, operand_a, operand_b) gives one
// result beat on out_ch (value, mode_error). in_ch.ready is high only while
// the block is idle, so one operation is in flight at a time. the cfg port
// writes mode, n, g, h, p and the decrypt inverse; the user must write them
// only while idle, as the block does not enforce it. all modular work runs
// on one bit-serial add/compare unit, with W the larger of MOD_BITS and
// 2*PRIME_BITS (24 at default). the run time of decrypt is set by the size
// of p. a mode error or a degenerate modulus skips the unit and goes
// straight from idle to the output state.
// reset returns the registers to mode 0, n = 2, p = 2, others 0, and empties
// the result register. a finished result waits in the output register while
// out_ch.ready is low; the block accepts the next beat meanwhile, and holds
// the following result until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "okamoto_uchiyama_cipher_unit_top_macros.svh"

module okamoto_uchiyama_cipher_unit_top import ou_pkg::*; #(
  parameter int MOD_BITS   = DEF_MOD_BITS,
  parameter int PRIME_BITS = DEF_PRIME_BITS,
  localparam int CFG_BITS  = (MOD_BITS > PRIME_BITS) ? MOD_BITS : PRIME_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  ou_in_if.sink                        in_ch,
  ou_out_if.source                     out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  localparam int AW = (MOD_BITS > 2 * PRIME_BITS) ? MOD_BITS : 2 * PRIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POW_RED,
    S_POW_TEST,
    S_POW_MUL,
    S_POW_SQ,
    S_ADD_RA,
    S_ADD_RB,
    S_DEC_DIV,
    S_DEC_INV,
    S_FIN_MUL,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_ENC1,
    PH_ENC2,
    PH_SCALAR,
    PH_DEC
  } pow_ph_t;

  // configuration registers
  logic                  mode_r;
  logic [MOD_BITS-1:0]   n_r;
  logic [MOD_BITS-1:0]   g_r;
  logic [MOD_BITS-1:0]   h_r;
  logic [PRIME_BITS-1:0] p_r;
  logic [PRIME_BITS-1:0] inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      n_r    <= MOD_BITS'(2);
      g_r    <= '0;
      h_r    <= '0;
      p_r    <= PRIME_BITS'(2);
      inv_r  <= '0;
    end else if (cfg_we) begin
      unique case (ou_cfg_idx_t'(cfg_index))
        CFG_MODE:    mode_r <= cfg_wdata[0];
        CFG_MODULUS: n_r    <= cfg_wdata[MOD_BITS-1:0];
        CFG_BASE_G:  g_r    <= cfg_wdata[MOD_BITS-1:0];
        CFG_BASE_H:  h_r    <= cfg_wdata[MOD_BITS-1:0];
        CFG_PRIME:   p_r    <= cfg_wdata[PRIME_BITS-1:0];
        CFG_INVERSE: inv_r  <= cfg_wdata[PRIME_BITS-1:0];
        default:     ;
      endcase
    end
  end

  state_t              state_r;
  pow_ph_t             ph_r;
  logic [AW-1:0]       base_r;
  logic [AW-1:0]       acc_r;
  logic [AW-1:0]       exp_r;
  logic [AW-1:0]       t_r;
  logic [MOD_BITS-1:0] hold_r;
  logic [AW-1:0]       res_r;
  logic                err_r;
  logic                out_valid_r;
  logic [MOD_BITS-1:0] out_value_r;
  logic                out_err_r;

  logic                start_r;
  ou_cmd_t             cmd_r;
  logic [AW-1:0]       ar_a_r;
  logic [AW-1:0]       ar_b_r;
  logic [AW-1:0]       ar_m_r;

  ou_req_t             ar_req;
  ou_rsp_t             ar_rsp;
  logic [AW-1:0]       ar_rem;
  logic [AW-1:0]       ar_quo;

  logic                        in_acc;
  logic                        n_small;
  logic [2*PRIME_BITS-1:0]     pp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign n_small     = (n_r < MOD_BITS'(2));
  assign pp          = (2*PRIME_BITS)'(p_r) * (2*PRIME_BITS)'(p_r);

  assign ar_req.start = start_r;
  assign ar_req.cmd   = cmd_r;

  ou_arith #(.W(AW)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ar_req),
    .opa   (ar_a_r),
    .opb   (ar_b_r),
    .modv  (ar_m_r),
    .rsp   (ar_rsp),
    .rem   (ar_rem),
    .quo   (ar_quo)
  );

  // start_r is a one-cycle pulse: set on entry to a unit wait, cleared while waiting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      if (out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_r  <= '0;
            hold_r <= in_ch.operand_b;
            cmd_r  <= CMD_REDUCE;
            unique case (ou_action_t'(in_ch.action))
              ACT_ENCRYPT: begin
                err_r <= mode_r;
                if (mode_r) begin
                  state_r <= S_OUT;
                end else if (n_small) begin
                  state_r <= S_OUT;
                end else begin
                  ar_m_r  <= AW'(n_r);
                  ar_a_r  <= AW'(g_r);
                  exp_r   <= AW'(in_ch.operand_a);
                  ph_r    <= PH_ENC1;
                  start_r <= 1'b1;
                  state_r <= S_POW_RED;
                end
              end
              ACT_DECRYPT: begin
                err_r <= !mode_r;
                if (!mode_r) begin
                  state_r <= S_OUT;
                end else if (p_r < PRIME_BITS'(2)) begin
                  state_r <= S_OUT;
                end else begin
                  ar_m_r  <= AW'(pp);
                  ar_a_r  <= AW'(in_ch.operand_a);
                  exp_r   <= AW'(p_r - PRIME_BITS'(1));
                  ph_r    <= PH_DEC;
                  start_r <= 1'b1;
                  state_r <= S_POW_RED;
                end
              end
              ACT_ADD: begin
                err_r <= 1'b0;
                if (n_small) begin
                  state_r <= S_OUT;
                end else begin
                  ar_m_r  <= AW'(n_r);
                  ar_a_r  <= AW'(in_ch.operand_a);
                  start_r <= 1'b1;
                  state_r <= S_ADD_RA;
                end
              end
              ACT_SCALAR: begin
                err_r <= 1'b0;
                if (n_small) begin
                  state_r <= S_OUT;
                end else begin
                  ar_m_r  <= AW'(n_r);
                  ar_a_r  <= AW'(in_ch.operand_a);
                  exp_r   <= AW'(in_ch.operand_b);
                  ph_r    <= PH_SCALAR;
                  start_r <= 1'b1;
                  state_r <= S_POW_RED;
                end
              end
            endcase
          end
        end
        S_POW_RED: begin
          if (ar_rsp.done) begin
            base_r  <= ar_rem;
            acc_r   <= AW'(1);
            state_r <= S_POW_TEST;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_POW_TEST: begin
          if (exp_r == '0) begin
            // exponentiation finished, acc_r holds the power
            unique case (ph_r)
              PH_ENC1: begin
                t_r     <= acc_r;
                exp_r   <= AW'(hold_r);
                ph_r    <= PH_ENC2;
                cmd_r   <= CMD_REDUCE;
                ar_a_r  <= AW'(h_r);
                start_r <= 1'b1;
                state_r <= S_POW_RED;
              end
              PH_ENC2: begin
                cmd_r   <= CMD_MULMOD;
                ar_a_r  <= t_r;
                ar_b_r  <= acc_r;
                start_r <= 1'b1;
                state_r <= S_FIN_MUL;
              end
              PH_SCALAR: begin
                res_r   <= acc_r;
                state_r <= S_OUT;
              end
              PH_DEC: begin
                cmd_r   <= CMD_REDUCE;
                ar_m_r  <= AW'(p_r);
                start_r <= 1'b1;
                if (acc_r == '0) begin
                  // zero power gives L = 0
                  t_r     <= '0;
                  ar_a_r  <= AW'(inv_r);
                  state_r <= S_DEC_INV;
                end else begin
                  ar_a_r  <= acc_r - AW'(1);
                  state_r <= S_DEC_DIV;
                end
              end
            endcase
          end else if (exp_r[0]) begin
            cmd_r   <= CMD_MULMOD;
            ar_a_r  <= acc_r;
            ar_b_r  <= base_r;
            start_r <= 1'b1;
            state_r <= S_POW_MUL;
          end else begin
            exp_r <= exp_r >> 1;
            if (exp_r[AW-1:1] != '0) begin
              cmd_r   <= CMD_MULMOD;
              ar_a_r  <= base_r;
              ar_b_r  <= base_r;
              start_r <= 1'b1;
              state_r <= S_POW_SQ;
            end
          end
        end
        S_POW_MUL: begin
          if (ar_rsp.done) begin
            acc_r <= ar_rem;
            exp_r <= exp_r >> 1;
            if (exp_r[AW-1:1] != '0) begin
              cmd_r   <= CMD_MULMOD;
              ar_a_r  <= base_r;
              ar_b_r  <= base_r;
              start_r <= 1'b1;
              state_r <= S_POW_SQ;
            end else begin
              state_r <= S_POW_TEST;
            end
          end else begin
            start_r <= 1'b0;
          end
        end
        S_POW_SQ: begin
          if (ar_rsp.done) begin
            base_r  <= ar_rem;
            state_r <= S_POW_TEST;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_ADD_RA: begin
          if (ar_rsp.done) begin
            t_r     <= ar_rem;
            cmd_r   <= CMD_REDUCE;
            ar_a_r  <= AW'(hold_r);
            start_r <= 1'b1;
            state_r <= S_ADD_RB;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_ADD_RB: begin
          if (ar_rsp.done) begin
            cmd_r   <= CMD_MULMOD;
            ar_a_r  <= t_r;
            ar_b_r  <= ar_rem;
            start_r <= 1'b1;
            state_r <= S_FIN_MUL;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_DEC_DIV: begin
          if (ar_rsp.done) begin
            t_r     <= ar_quo;
            cmd_r   <= CMD_REDUCE;
            ar_a_r  <= AW'(inv_r);
            start_r <= 1'b1;
            state_r <= S_DEC_INV;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_DEC_INV: begin
          if (ar_rsp.done) begin
            cmd_r   <= CMD_MULMOD;
            ar_a_r  <= t_r;
            ar_b_r  <= ar_rem;
            start_r <= 1'b1;
            state_r <= S_FIN_MUL;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_FIN_MUL: begin
          if (ar_rsp.done) begin
            res_r   <= ar_rem;
            state_r <= S_OUT;
          end else begin
            start_r <= 1'b0;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_r[MOD_BITS-1:0];
            out_err_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.mode_error = out_err_r;

  // an accepted beat always leaves idle
  `OU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ch.ready)
  // errored results carry a zero value
  `OU_ASSERT_SAME(a_err_zero, clk, rst_n, out_ch.valid && out_ch.mode_error, out_ch.value == '0)
  // the shared unit only runs under an active operation
  `OU_ASSERT_SAME(a_unit_owned, clk, rst_n, ar_rsp.busy, state_r != S_IDLE)

endmodule

`default_nettype wire
